// ----- src/bpme_pkg.sv -----
// Package with the shared types and constants of the progressive mean block.
package bpme_pkg;

   localparam int unsigned MaxBlocks      = 4096;
   localparam int unsigned MaxBlockLength = 65535;

   localparam logic [15:0] ResetBlockLength = 16'd100;
   localparam logic [12:0] ResetNumBlocks   = 13'd100;
   localparam logic [1:0]  ResetReportMode  = 2'd0;

   localparam logic [1:0] CsrBlockLength = 2'd0;
   localparam logic [1:0] CsrNumBlocks   = 2'd1;
   localparam logic [1:0] CsrReportMode  = 2'd2;

   localparam logic [1:0] ModeEvery = 2'd0;
   localparam logic [1:0] ModeLast  = 2'd1;
   localparam logic [1:0] ModeRoot  = 2'd2;

   // One finished block handed from the front part to the back part.
   typedef struct packed {
      logic signed [47:0] block_sum;
      logic [15:0]        block_len;
      logic               last;
      logic               report;
      logic [1:0]         mode;
   } block_type;

endpackage

// ----- src/bpme_front.sv -----
// Front part: accumulates samples into blocks and passes each finished block on.
module bpme_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_sample,
   input  logic [15:0]               block_length,
   input  logic [12:0]               num_blocks,
   input  logic [1:0]                report_mode,
   input  logic                      run_clear,
   output logic                      blk_valid,
   input  logic                      blk_ready,
   output bpme_pkg::block_type       blk_data
);

   logic signed [47:0] acc_ff, acc_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic [12:0]        blocks_ff, blocks_in;
   logic [15:0]        len;
   logic [12:0]        nb;
   logic [16:0]        cnt_next;
   logic [13:0]        blocks_next;
   logic               ends;
   logic signed [47:0] sum_now;
   logic [1:0]         mode;

   always_comb begin
      len = (block_length == 16'd0) ? 16'd1 : block_length;
      nb = (num_blocks == 13'd0) ? 13'd1 :
           ((num_blocks > 13'(bpme_pkg::MaxBlocks)) ? 13'(bpme_pkg::MaxBlocks) : num_blocks);
      mode = (report_mode == 2'd3) ? bpme_pkg::ModeLast : report_mode;
      cnt_next = {1'b0, cnt_ff} + 17'd1;
      blocks_next = {1'b0, blocks_ff} + 14'd1;
      sum_now = acc_ff + 48'(req_sample);
      ends = (cnt_next >= {1'b0, len});
   end

   assign req_ready = blk_ready;
   assign blk_valid = req_valid && ends;

   always_comb begin
      blk_data.block_sum = sum_now;
      blk_data.block_len = len;
      blk_data.last = (blocks_next >= {1'b0, nb});
      blk_data.mode = mode;
      blk_data.report = (mode == bpme_pkg::ModeEvery) || blk_data.last;
   end

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      blocks_in = blocks_ff;
      if (req_valid && req_ready) begin
         if (ends) begin
            acc_in = '0;
            cnt_in = '0;
            blocks_in = blk_data.last ? 13'd0 : blocks_next[12:0];
         end else begin
            acc_in = sum_now;
            cnt_in = cnt_next[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || run_clear) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         blocks_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         blocks_ff <= blocks_in;
      end
   end

endmodule

// ----- src/bpme_queue.sv -----
// Two-entry queue of finished blocks between the front and back parts.
module bpme_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bpme_pkg::block_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output bpme_pkg::block_type out_data
);

   bpme_pkg::block_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> (cnt_ff == 2'd2))
      else $error("full queue lost an entry");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !pop)
      else $error("pop from empty queue");

endmodule

// ----- src/bpme_back.sv -----
// Back part: block mean, progressive sums, error and square root, one block at a time.
module bpme_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                blk_valid,
   output logic                blk_ready,
   input  bpme_pkg::block_type blk_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_mean_value,
   output logic [30:0]         rsp_error_value,
   output logic [12:0]         rsp_blocks_counted,
   output logic                rsp_run_done,
   output logic                rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV1, S_SQ1, S_ACC, S_DIV2, S_DIV3, S_SQ2, S_DIV4, S_ROOT1,
      S_ROOT2, S_DIV5, S_OUT
   } state_type;

   state_type state_ff;
   bpme_pkg::block_type blk_ff;

   logic signed [47:0] som_ff;
   logic [63:0]        sos_ff;
   logic [12:0]        n_ff;

   logic signed [47:0] mean_ff;
   logic signed [47:0] pm_ff;
   logic [63:0]        ms_ff;
   logic [63:0]        sq_ff;
   logic [63:0]        err_ff;
   logic [63:0]        root_ff;

   // Shared restoring divider, one quotient bit per cycle.
   logic [63:0]  dq_ff;
   logic [64:0]  drem_ff;
   logic [63:0]  dden_ff;
   logic [6:0]   dcnt_ff;
   logic         dneg_ff;
   logic         dbusy_ff;
   logic [64:0]  dtrial;
   logic [64:0]  dshift;

   // Shared integer square root, one result bit per cycle.
   logic [63:0]  rx_ff, rres_ff, rbit_ff;
   logic         rbusy_ff;
   logic [63:0]  rsum;

   // Multiplier for squares; its product is registered into sq_ff.
   logic [31:0]  mabs;
   logic [63:0]  mprod;

   logic [63:0]        diff;
   logic signed [47:0] som_next;
   logic [47:0]        blk_abs;
   logic [47:0]        som_abs;

   assign blk_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      dshift = {drem_ff[63:0], dq_ff[63]};
      dtrial = dshift - {1'b0, dden_ff};
      rsum = rres_ff + rbit_ff;
      mprod = 64'(mabs) * 64'(mabs);
      diff = (ms_ff > sq_ff) ? ms_ff - sq_ff : 64'd0;
      som_next = som_ff + mean_ff;
      blk_abs = blk_data.block_sum[47] ? 48'(-blk_data.block_sum)
                                       : 48'(blk_data.block_sum);
      som_abs = som_next[47] ? 48'(-som_next) : 48'(som_next);
   end

   always_comb begin
      mabs = (state_ff == S_SQ1) ? (mean_ff[47] ? 32'(-mean_ff) : 32'(mean_ff))
                                 : (pm_ff[47] ? 32'(-pm_ff) : 32'(pm_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         som_ff <= '0;
         sos_ff <= '0;
         n_ff <= '0;
         dbusy_ff <= 1'b0;
         rbusy_ff <= 1'b0;
      end else begin
         if (dbusy_ff) begin
            if (dtrial[64]) begin
               drem_ff <= dshift;
               dq_ff <= {dq_ff[62:0], 1'b0};
            end else begin
               drem_ff <= dtrial;
               dq_ff <= {dq_ff[62:0], 1'b1};
            end
            dcnt_ff <= dcnt_ff - 7'd1;
            if (dcnt_ff == 7'd1) begin
               dbusy_ff <= 1'b0;
            end
         end
         if (rbusy_ff) begin
            if (rbit_ff == 64'd0) begin
               rbusy_ff <= 1'b0;
            end else if (rx_ff >= rsum) begin
               rx_ff <= rx_ff - rsum;
               rres_ff <= (rres_ff >> 1) + rbit_ff;
               rbit_ff <= rbit_ff >> 2;
            end else begin
               rres_ff <= rres_ff >> 1;
               rbit_ff <= rbit_ff >> 2;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (blk_valid) begin
                  blk_ff <= blk_data;
                  dq_ff <= 64'(blk_abs);
                  drem_ff <= '0;
                  dden_ff <= 64'(blk_data.block_len);
                  dneg_ff <= blk_data.block_sum[47];
                  dcnt_ff <= 7'd64;
                  dbusy_ff <= 1'b1;
                  state_ff <= S_DIV1;
               end
            end
            S_DIV1: begin
               if (!dbusy_ff) begin
                  mean_ff <= dneg_ff ? 48'(-dq_ff) : 48'(dq_ff);
                  state_ff <= S_SQ1;
               end
            end
            S_SQ1: begin
               sq_ff <= {16'd0, mprod[63:16]};
               state_ff <= S_ACC;
            end
            S_ACC: begin
               som_ff <= som_next;
               sos_ff <= sos_ff + sq_ff;
               n_ff <= n_ff + 13'd1;
               dneg_ff <= som_next[47];
               dq_ff <= 64'(som_abs);
               drem_ff <= '0;
               dden_ff <= 64'(n_ff + 13'd1);
               dcnt_ff <= 7'd64;
               dbusy_ff <= 1'b1;
               state_ff <= S_DIV2;
            end
            S_DIV2: begin
               if (!dbusy_ff) begin
                  pm_ff <= dneg_ff ? 48'(-dq_ff) : 48'(dq_ff);
                  dq_ff <= sos_ff;
                  drem_ff <= '0;
                  dden_ff <= 64'(n_ff);
                  dcnt_ff <= 7'd64;
                  dbusy_ff <= 1'b1;
                  state_ff <= S_DIV3;
               end
            end
            S_DIV3: begin
               if (!dbusy_ff) begin
                  ms_ff <= dq_ff;
                  state_ff <= S_SQ2;
               end
            end
            S_SQ2: begin
               sq_ff <= {16'd0, mprod[63:16]};
               state_ff <= S_DIV4;
               err_ff <= '0;
               if (n_ff > 13'd1) begin
                  dq_ff <= '0;
                  dcnt_ff <= 7'd0;
               end
            end
            S_DIV4: begin
               if (n_ff > 13'd1) begin
                  dq_ff <= diff;
                  drem_ff <= '0;
                  dden_ff <= 64'(n_ff - 13'd1);
                  dcnt_ff <= 7'd64;
                  dbusy_ff <= 1'b1;
                  state_ff <= S_ROOT1;
               end else begin
                  state_ff <= S_ROOT2;
                  rres_ff <= '0;
                  rx_ff <= {pm_ff[47:0], 16'd0};
                  rbit_ff <= 64'h4000_0000_0000_0000;
                  rbusy_ff <= 1'b1;
               end
            end
            S_ROOT1: begin
               if (!dbusy_ff && !rbusy_ff && dcnt_ff == 7'd0) begin
                  rx_ff <= {dq_ff[47:0], 16'd0};
                  rres_ff <= '0;
                  rbit_ff <= 64'h4000_0000_0000_0000;
                  rbusy_ff <= 1'b1;
                  dcnt_ff <= 7'd127;
               end else if (dcnt_ff == 7'd127 && !rbusy_ff) begin
                  err_ff <= rres_ff;
                  rres_ff <= '0;
                  rx_ff <= {pm_ff[47:0], 16'd0};
                  rbit_ff <= 64'h4000_0000_0000_0000;
                  rbusy_ff <= 1'b1;
                  state_ff <= S_ROOT2;
               end
            end
            S_ROOT2: begin
               if (!rbusy_ff) begin
                  root_ff <= rres_ff;
                  if (blk_ff.mode == bpme_pkg::ModeRoot && blk_ff.report && !pm_ff[47]
                      && pm_ff != 48'd0) begin
                     dq_ff <= {err_ff[47:0], 16'd0};
                     drem_ff <= '0;
                     dden_ff <= {rres_ff[62:0], 1'b0};
                     dcnt_ff <= 7'd64;
                     dbusy_ff <= 1'b1;
                     state_ff <= S_DIV5;
                  end else begin
                     state_ff <= blk_ff.report ? S_OUT : S_IDLE;
                  end
                  rsp_blocks_counted <= n_ff;
                  rsp_run_done <= blk_ff.last;
                  rsp_status <= 1'b0;
                  rsp_mean_value <= pm_ff[31:0];
                  rsp_error_value <= (err_ff > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : err_ff[30:0];
                  if (blk_ff.mode == bpme_pkg::ModeRoot) begin
                     rsp_mean_value <= '0;
                     rsp_error_value <= '0;
                     rsp_status <= 1'b1;
                  end
                  if (blk_ff.last) begin
                     som_ff <= '0;
                     sos_ff <= '0;
                     n_ff <= '0;
                  end
               end
            end
            S_DIV5: begin
               if (!dbusy_ff) begin
                  rsp_mean_value <= root_ff[31:0];
                  rsp_error_value <= (dq_ff > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dq_ff[30:0];
                  rsp_status <= 1'b0;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !blk_ready)
      else $error("block taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      !(dbusy_ff && rbusy_ff))
      else $error("divider and root both running");

endmodule

// ----- src/blocking_progressive_mean_error.sv -----
// Top level of the blocking-method progressive mean and error block.
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_sample
//  rsp     | out       | rsp_valid/rsp_ready  | mean, error, blocks, run_done, status
//  csr     | in        | csr_write            | csr_index, csr_data
// A sample is taken every cycle while the block queue has room.
// Each block end is handled in the back part by the
// shared one-bit-per-cycle divider and square-root unit; a two-entry queue
// lets accumulation continue meanwhile. Reset is synchronous and clears all
// sums. A stalled result holds the back part and, once the queue fills, the input.
module blocking_progressive_mean_error (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_mean_value,
   output logic [30:0]        rsp_error_value,
   output logic [12:0]        rsp_blocks_counted,
   output logic               rsp_run_done,
   output logic               rsp_status,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   logic [15:0] block_length_ff;
   logic [12:0] num_blocks_ff;
   logic [1:0]  report_mode_ff;

   logic f_valid, f_ready, b_valid, b_ready;
   bpme_pkg::block_type f_data, b_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= bpme_pkg::ResetBlockLength;
         num_blocks_ff <= bpme_pkg::ResetNumBlocks;
         report_mode_ff <= bpme_pkg::ResetReportMode;
      end else if (csr_write) begin
         case (csr_index)
            bpme_pkg::CsrBlockLength: block_length_ff <= csr_data;
            bpme_pkg::CsrNumBlocks: num_blocks_ff <= csr_data[12:0];
            bpme_pkg::CsrReportMode: report_mode_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   bpme_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample(req_sample),
      .block_length(block_length_ff), .num_blocks(num_blocks_ff),
      .report_mode(report_mode_ff), .run_clear(1'b0),
      .blk_valid(f_valid), .blk_ready(f_ready), .blk_data(f_data)
   );

   bpme_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   bpme_back u_back (
      .clock(clock), .reset(reset),
      .blk_valid(b_valid), .blk_ready(b_ready), .blk_data(b_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mean_value(rsp_mean_value), .rsp_error_value(rsp_error_value),
      .rsp_blocks_counted(rsp_blocks_counted), .rsp_run_done(rsp_run_done),
      .rsp_status(rsp_status)
   );

endmodule

// ----- test/blocking_progressive_mean_error_checker.sv -----
// Checker that predicts and compares every result of the progressive mean block.
`timescale 1ns / 100ps
module blocking_progressive_mean_error_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_sample,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_mean_value,
   input  logic [30:0]        rsp_error_value,
   input  logic [12:0]        rsp_blocks_counted,
   input  logic               rsp_run_done,
   input  logic               rsp_status,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 failures,
   output int                 pending
);

   typedef struct {
      logic [31:0] mean_value;
      logic [30:0] error_value;
      logic [12:0] blocks_counted;
      logic        run_done;
      logic        status;
   } mean_result_type;

   mean_result_type expected_results[$];

   logic [15:0] cfg_len;
   logic [12:0] cfg_blocks;
   logic [1:0]  cfg_mode;

   longint          block_sum;
   int unsigned     block_fill;
   int unsigned     block_count;
   longint          means_total;
   longint unsigned squares_total;
   int              mismatches;

   function automatic longint unsigned floor_root(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned square_fixed(longint m);
      longint unsigned a;
      a = (m < 0) ? longint'(-m) : m;
      return (a * a) >> 16;
   endfunction

   function automatic logic [30:0] clip31(longint unsigned v);
      return (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
   endfunction

   task automatic accumulate_sample(input logic signed [31:0] s);
      longint          len;
      longint unsigned nb;
      logic [1:0]      mode;
      longint          mean;
      longint          pm;
      longint unsigned n;
      longint unsigned ms;
      longint unsigned pm2;
      longint unsigned diff;
      longint unsigned err;
      longint unsigned root;
      logic            last;
      mean_result_type r;
      len  = (cfg_len == 0) ? 1 : cfg_len;
      nb   = (cfg_blocks == 0) ? 1 : ((cfg_blocks > bpme_pkg::MaxBlocks) ?
                                      bpme_pkg::MaxBlocks : cfg_blocks);
      mode = (cfg_mode == 2'd3) ? bpme_pkg::ModeLast : cfg_mode;
      err  = 0;
      block_sum  += longint'(s);
      block_fill += 1;
      if (block_fill < len) return;
      mean = block_sum / len;
      block_sum  = 0;
      block_fill = 0;
      means_total   += mean;
      squares_total += square_fixed(mean);
      block_count   += 1;
      n    = block_count;
      last = (n >= nb);
      pm   = means_total / longint'(n);
      ms   = squares_total / n;
      pm2  = square_fixed(pm);
      diff = (ms > pm2) ? ms - pm2 : 0;
      if (n > 1) err = floor_root((diff / (n - 1)) << 16);
      if (last) begin
         block_sum = 0;
         block_fill = 0;
         block_count = 0;
         means_total = 0;
         squares_total = 0;
      end
      if (mode != bpme_pkg::ModeEvery && !last) return;
      r.blocks_counted = n[12:0];
      r.run_done = last;
      if (mode == bpme_pkg::ModeRoot) begin
         if (pm <= 0) begin
            r.mean_value = 0;
            r.error_value = 0;
            r.status = 1'b1;
         end else begin
            root = floor_root(longint'(pm) << 16);
            r.mean_value = root[31:0];
            r.error_value = clip31((err << 16) / (2 * root));
            r.status = 1'b0;
         end
      end else begin
         r.mean_value = pm[31:0];
         r.error_value = clip31(err);
         r.status = 1'b0;
      end
      expected_results.push_back(r);
   endtask

   always @(posedge clock) begin
      mean_result_type e;
      if (reset) begin
         cfg_len = bpme_pkg::ResetBlockLength;
         cfg_blocks = bpme_pkg::ResetNumBlocks;
         cfg_mode = bpme_pkg::ResetReportMode;
         block_sum = 0;
         block_fill = 0;
         block_count = 0;
         means_total = 0;
         squares_total = 0;
         mismatches = 0;
         expected_results.delete();
         failures <= 0;
         pending <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               bpme_pkg::CsrBlockLength: cfg_len = csr_data;
               bpme_pkg::CsrNumBlocks: cfg_blocks = csr_data[12:0];
               bpme_pkg::CsrReportMode: cfg_mode = csr_data[1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches += 1;
               if (mismatches <= 10) $display("Unexpected result transfer: mean %h", rsp_mean_value);
            end else begin
               e = expected_results.pop_front();
               if (e.mean_value !== rsp_mean_value || e.error_value !== rsp_error_value
                   || e.blocks_counted !== rsp_blocks_counted || e.run_done !== rsp_run_done
                   || e.status !== rsp_status) begin
                  mismatches += 1;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %h %h %0d %b %b, got %h %h %0d %b %b",
                              e.mean_value, e.error_value, e.blocks_counted, e.run_done,
                              e.status, rsp_mean_value, rsp_error_value, rsp_blocks_counted,
                              rsp_run_done, rsp_status);
               end
            end
         end
         if (req_valid && req_ready) accumulate_sample(req_sample);
         failures <= mismatches;
         pending <= expected_results.size();
      end
   end

endmodule

// ----- test/blocking_progressive_mean_error_tb.sv -----
// Top of the testbench: clock, reset, stimulus and verdict for the progressive mean block.
`timescale 1ns / 100ps
module blocking_progressive_mean_error_tb;

   localparam logic [1:0] CsrUnused = 2'd3;
   localparam int DrainCycles = 1500;
   localparam int LongHold = 3000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_sample;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_mean_value;
   logic [30:0]        rsp_error_value;
   logic [12:0]        rsp_blocks_counted;
   logic               rsp_run_done;
   logic               rsp_status;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [15:0]        csr_data;
   int                 failures;
   int                 pending;
   logic               send_fast;
   logic               take_fast;
   logic               hold_request;

   blocking_progressive_mean_error dut (.*);

   blocking_progressive_mean_error_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // Receiver: random hold-offs per transfer unless take_fast is set, plus one long stall on request.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            hold_request = 1'b0;
         end
         gap = take_fast ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_sample(input logic [31:0] s);
      int gap;
      gap = send_fast ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] len, input logic [12:0] nb,
                             input logic [1:0] mode, input bit extra);
      req_valid <= 1'b0;
      csr_write <= 1'b1;
      csr_index <= bpme_pkg::CsrBlockLength;
      csr_data <= len;
      @(posedge clock);
      csr_index <= bpme_pkg::CsrNumBlocks;
      csr_data <= {3'b0, nb};
      @(posedge clock);
      csr_index <= bpme_pkg::CsrReportMode;
      csr_data <= {14'b0, mode};
      @(posedge clock);
      if (extra) begin
         csr_index <= CsrUnused;
         csr_data <= 16'($urandom);
         @(posedge clock);
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample(input int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         2: return $urandom & 32'h7FFF_FFFF;
         default: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   initial begin
      int kind;
      int count;
      logic [1:0] mode;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_fast = 1'b0;
      take_fast = 1'b0;
      hold_request = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      repeat (100) send_sample(pick_sample(1));
      drain();
      set_config(16'd1, 13'd3, bpme_pkg::ModeEvery, 1'b0);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0000);
      drain();
      set_config(16'd2, 13'd2, bpme_pkg::ModeRoot, 1'b0);
      send_sample(-32'sd5);
      send_sample(-32'sd7);
      send_sample(32'sd3);
      send_sample(32'sd1);
      repeat (4) send_sample(32'h7FFF_FFFF);
      drain();
      set_config(16'd0, 13'd0, 2'd3, 1'b1);
      repeat (3) send_sample(pick_sample(0));
      drain();
      set_config(16'd1, 13'h1FFF, bpme_pkg::ModeLast, 1'b0);
      repeat (4) send_sample(pick_sample(3));
      drain();
      set_config(16'd3, 13'd4096, bpme_pkg::ModeEvery, 1'b0);
      repeat (6) send_sample(pick_sample(0));
      drain();

      // Pressure: the receiver stalls while single-sample blocks keep arriving.
      set_config(16'd1, 13'd40, bpme_pkg::ModeEvery, 1'b0);
      hold_request = 1'b1;
      send_fast = 1'b1;
      repeat (20) send_sample(pick_sample(0));
      send_fast = 1'b0;
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         mode = 2'($urandom_range(0, 3));
         set_config(16'($urandom_range(1, 6)), 13'($urandom_range(1, 8)), mode, 1'b0);
         send_fast = ($urandom_range(0, 3) == 0);
         take_fast = ($urandom_range(0, 3) == 0);
         kind = (mode == bpme_pkg::ModeRoot) ? 2 : $urandom_range(0, 3);
         count = $urandom_range(15, 30);
         for (int i = 0; i < count; i++) begin
            send_sample(pick_sample(kind));
            if (phase == 6 && i == count / 2) begin
               req_valid <= 1'b0;
               drain();
            end
         end
         send_fast = 1'b0;
         take_fast = 1'b0;
         drain();
      end

      req_valid <= 1'b0;
      drain();
      if (failures == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/bpme_pkg.sv
src/bpme_front.sv
src/bpme_queue.sv
src/bpme_back.sv
src/blocking_progressive_mean_error.sv
test/blocking_progressive_mean_error_checker.sv
test/blocking_progressive_mean_error_tb.sv
